// File: design/ipap_pkg.sv
// Shared types, phase codes and character constants for the IPv4 address and port parser.
// No dependencies; ipap_in_stage, ipap_step and the top level import this package.
`default_nettype none

package ipap_pkg;

  localparam int ChW     = 8;
  localparam int AccW    = 17;
  localparam int IpW     = 32;
  localparam int PortW   = 16;
  localparam int PhaseW  = 3;
  localparam int IdxW    = 2;
  localparam int OutDataW = 48;

  localparam logic [PhaseW-1:0] PH_OCT_START   = 3'd0;
  localparam logic [PhaseW-1:0] PH_OCT_DIGITS  = 3'd1;
  localparam logic [PhaseW-1:0] PH_PORT_START  = 3'd2;
  localparam logic [PhaseW-1:0] PH_PORT_DIGITS = 3'd3;
  localparam logic [PhaseW-1:0] PH_DONE        = 3'd4;
  localparam logic [PhaseW-1:0] PH_FAIL        = 3'd5;

  localparam logic [AccW-1:0] OCTET_MAX = 17'd255;
  localparam logic [AccW-1:0] ACC_SAT   = 17'd65536;
  localparam logic [IdxW-1:0] LAST_OCTET = 2'd3;

  localparam logic [ChW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ChW-1:0] CH_COLON = 8'h3A;
  localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ChW-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [IdxW-1:0]   octet_index;
    logic [AccW-1:0]   accumulator;
    logic [IpW-1:0]    address_shift;
    logic [PortW-1:0]  port_hold;
  } ipap_state_t;

  typedef struct packed {
    logic             ok;
    logic [IpW-1:0]   ip;
    logic [PortW-1:0] port;
  } ipap_res_t;

  localparam ipap_state_t STATE_RESET = '{
    phase:         PH_OCT_START,
    octet_index:   '0,
    accumulator:   '0,
    address_shift: '0,
    port_hold:     '0
  };

endpackage

`default_nettype wire

// File: design/ipap_in_stage.sv
// Input register of the parser: holds one character transfer until the step logic takes it.
// Depends on ipap_pkg.
`default_nettype none

module ipap_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [ipap_pkg::ChW-1:0] in_tdata,
  input  wire logic                  in_tlast,
  input  wire logic                  advance,
  output logic                       item_valid,
  output logic [ipap_pkg::ChW-1:0]   item_ch,
  output logic                       item_last
);
  import ipap_pkg::*;

  logic           valid_r;
  logic           valid_nxt;
  logic [ChW-1:0] ch_r;
  logic           last_r;

  // The register refills in the same cycle that its content moves on.
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item_valid = valid_r;
  assign item_ch    = ch_r;
  assign item_last  = last_r;

endmodule

`default_nettype wire

// File: design/ipap_step.sv
// Combinational parser step: next state and end-of-text verdict for one character.
// Depends on ipap_pkg.
`default_nettype none

module ipap_step (
  input  wire ipap_pkg::ipap_state_t     st,
  input  wire logic [ipap_pkg::ChW-1:0]  ch,
  input  wire logic                      last,
  output ipap_pkg::ipap_state_t          st_nxt,
  output ipap_pkg::ipap_res_t            res
);
  import ipap_pkg::*;

  logic            is_dig;
  logic [3:0]      dig;
  logic [20:0]     mac;
  logic [AccW-1:0] acc_sat;
  logic            oct_ok;
  logic            port_ok;

  assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig    = ch[3:0];
  // acc * 10 + digit, then clamp so long runs stay out of range.
  assign mac     = {1'b0, st.accumulator, 3'b000} + {3'b000, st.accumulator, 1'b0}
                 + {17'd0, dig};
  assign acc_sat = (mac > {4'd0, ACC_SAT}) ? ACC_SAT : mac[AccW-1:0];
  assign oct_ok  = st.accumulator <= OCTET_MAX;
  assign port_ok = (st.accumulator != '0) && (st.accumulator < ACC_SAT);

  always_comb begin
    res = '0;
    if (st.phase == PH_OCT_DIGITS) begin
      if ((st.octet_index == LAST_OCTET) && oct_ok) begin
        res.ok = 1'b1;
        res.ip = {st.address_shift[IpW-9:0], st.accumulator[7:0]};
      end
    end else if (st.phase == PH_PORT_DIGITS) begin
      if (port_ok) begin
        res.ok   = 1'b1;
        res.ip   = st.address_shift;
        res.port = st.accumulator[PortW-1:0];
      end
    end else if (st.phase == PH_DONE) begin
      res.ok   = 1'b1;
      res.ip   = st.address_shift;
      res.port = st.port_hold;
    end
  end

  always_comb begin
    st_nxt = st;
    if (last) begin
      st_nxt = STATE_RESET;
    end else begin
      unique case (st.phase) inside
        PH_OCT_START, PH_PORT_START: begin
          if (is_dig) begin
            st_nxt.accumulator = {13'd0, dig};
            st_nxt.phase = (st.phase == PH_OCT_START) ? PH_OCT_DIGITS : PH_PORT_DIGITS;
          end else begin
            st_nxt.phase = PH_FAIL;
          end
        end
        PH_OCT_DIGITS: begin
          if (is_dig) begin
            st_nxt.accumulator = acc_sat;
          end else if (!oct_ok) begin
            st_nxt.phase = PH_FAIL;
          end else begin
            st_nxt.address_shift = {st.address_shift[IpW-9:0], st.accumulator[7:0]};
            st_nxt.accumulator   = '0;
            if (st.octet_index != LAST_OCTET) begin
              if (ch == CH_DOT) begin
                st_nxt.octet_index = st.octet_index + 2'd1;
                st_nxt.phase       = PH_OCT_START;
              end else begin
                st_nxt.phase = PH_FAIL;
              end
            end else if (ch == CH_COLON) begin
              st_nxt.phase = PH_PORT_START;
            end else begin
              st_nxt.port_hold = '0;
              st_nxt.phase     = PH_DONE;
            end
          end
        end
        PH_PORT_DIGITS: begin
          if (is_dig) begin
            st_nxt.accumulator = acc_sat;
          end else if (port_ok) begin
            st_nxt.port_hold   = st.accumulator[PortW-1:0];
            st_nxt.accumulator = '0;
            st_nxt.phase       = PH_DONE;
          end else begin
            st_nxt.phase = PH_FAIL;
          end
        end
        PH_DONE: begin
          st_nxt = st;
        end
        default: begin
          st_nxt.phase = PH_FAIL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ipv4_address_port_parser.sv
// Top level of the IPv4 dotted-decimal address and port parser.
// Depends on ipap_pkg, ipap_in_stage and ipap_step.
//
// Each input transfer carries one ASCII character; a transfer with in_tlast set ends the
// string, its character is ignored, and it produces exactly one result transfer, after which
// the parser is back in its reset state. The block takes one character every cycle while no end
// transfer is waiting: a character passes through the input register, then the parser state
// and the result register are updated from it, and out_tvalid is driven from the result register.
// An end transfer waits in the input register while an earlier result is still held on the
// output, and the characters behind it wait with it.
// out_tuser is 1 for a legal address; on a failed parse the address and port are zero.
`default_nettype none

module ipv4_address_port_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] ip_value, [47:32] port_value
  output logic             out_tuser   // valid_res
);
  import ipap_pkg::*;

  logic            item_valid;
  logic [ChW-1:0]  item_ch;
  logic            item_last;
  logic            advance;
  ipap_state_t     state_r;
  ipap_state_t     state_nxt;
  ipap_res_t       res;
  ipap_res_t       res_r;
  logic            out_valid_r;
  logic            out_valid_nxt;

  ipap_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item_ch    (item_ch),
    .item_last  (item_last)
  );

  ipap_step u_step (
    .st     (state_r),
    .ch     (item_ch),
    .last   (item_last),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Plain characters never wait; an end item needs a free result register.
  assign advance = item_valid && (!item_last || !out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (advance && item_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_last) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.port, res_r.ip};
  assign out_tuser  = res_r.ok;

endmodule

`default_nettype wire

// File: design/ipap_checker.sv
// Port-level checks for the IPv4 address and port parser, bound to its top level.
// Depends on ipv4_address_port_parser.
`default_nettype none

module ipap_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  // A held result keeps its contents until the transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A failed parse reports zero address and zero port.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 48'd0)
    else $error("failed parse with nonzero fields");

  // A result register stays empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // A result appearing on an empty output follows its end transfer through the input and result registers.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without end transfer");

endmodule

bind ipv4_address_port_parser ipap_checker u_ipap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for ipv4_address_port_parser: streams address strings, one
// character per transfer, and checks each verdict against a parser model kept here.
// Depends on ipap_pkg and the design files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipap_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int RandomChars = 1230;
  localparam int QuietTail   = 120;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           eot;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [7:0] ch
  logic                in_tlast = 1'b0; // end_of_text
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;       // [31:0] ip_value, [47:32] port_value
  logic                out_tuser;       // valid_res

  char_item_t char_q[$];
  logic [7:0] txt_q[$];
  ipap_res_t  verdict_q[$];

  int mismatch_count = 0;
  int results_total = 0;
  int results_seen = 0;
  int cycle_count = 0;

  // Parser model state.
  logic [PhaseW-1:0] prs_phase;
  logic [IdxW-1:0]   prs_octet;
  logic [AccW-1:0]   prs_acc;
  logic [IpW-1:0]    prs_addr;
  logic [PortW-1:0]  prs_port;

  ipv4_address_port_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic void parser_clear();
    prs_phase = PH_OCT_START;
    prs_octet = '0;
    prs_acc   = '0;
    prs_addr  = '0;
    prs_port  = '0;
  endfunction

  // Advances the model by one character; returns 1 with the verdict on an end transfer.
  function automatic bit parse_char(input logic [ChW-1:0] c, input logic eot,
                                    output ipap_res_t res);
    int unsigned grown;
    bit          is_dig;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    grown = 32'(prs_acc) * 10 + 32'(c - CH_ZERO);
    res = '0;
    if (eot) begin
      case (prs_phase)
        PH_OCT_DIGITS: begin
          if (prs_octet == LAST_OCTET && prs_acc <= OCTET_MAX) begin
            res.ok = 1'b1;
            res.ip = {prs_addr[23:0], prs_acc[7:0]};
          end
        end
        PH_PORT_DIGITS: begin
          if (prs_acc >= 1 && prs_acc < ACC_SAT) begin
            res.ok   = 1'b1;
            res.ip   = prs_addr;
            res.port = prs_acc[PortW-1:0];
          end
        end
        PH_DONE: begin
          res.ok   = 1'b1;
          res.ip   = prs_addr;
          res.port = prs_port;
        end
        default: ;
      endcase
      parser_clear();
      return 1'b1;
    end
    case (prs_phase) inside
      PH_OCT_START, PH_PORT_START: begin
        if (is_dig) begin
          prs_acc   = AccW'(c - CH_ZERO);
          prs_phase = (prs_phase == PH_OCT_START) ? PH_OCT_DIGITS : PH_PORT_DIGITS;
        end else begin
          prs_phase = PH_FAIL;
        end
      end
      PH_OCT_DIGITS: begin
        if (is_dig) begin
          prs_acc = (grown > ACC_SAT) ? ACC_SAT : grown[AccW-1:0];
        end else if (prs_acc > OCTET_MAX) begin
          prs_phase = PH_FAIL;
        end else begin
          prs_addr = {prs_addr[23:0], prs_acc[7:0]};
          prs_acc  = '0;
          if (prs_octet < LAST_OCTET) begin
            if (c == CH_DOT) begin
              prs_octet = prs_octet + 1'b1;
              prs_phase = PH_OCT_START;
            end else begin
              prs_phase = PH_FAIL;
            end
          end else if (c == CH_COLON) begin
            prs_phase = PH_PORT_START;
          end else begin
            prs_port  = '0;
            prs_phase = PH_DONE;
          end
        end
      end
      PH_PORT_DIGITS: begin
        if (is_dig) begin
          prs_acc = (grown > ACC_SAT) ? ACC_SAT : grown[AccW-1:0];
        end else if (prs_acc >= 1 && prs_acc < ACC_SAT) begin
          prs_port  = prs_acc[PortW-1:0];
          prs_acc   = '0;
          prs_phase = PH_DONE;
        end else begin
          prs_phase = PH_FAIL;
        end
      end
      PH_DONE: ;
      default: prs_phase = PH_FAIL;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- stimulus building

  task automatic add_text(input string s);
    foreach (s[i]) txt_q.push_back(s[i]);
  endtask

  // Moves the text buffer into the character stream and closes it with an end transfer.
  task automatic flush_text();
    foreach (txt_q[i]) char_q.push_back('{txt_q[i], 1'b0});
    txt_q.delete();
    char_q.push_back('{ChW'($urandom_range(0, 255)), 1'b1});
    results_total++;
  endtask

  function automatic string octet_text();
    case ($urandom_range(0, 19))
      0:       return "0";
      1:       return "255";
      2:       return $sformatf("%0d", $urandom_range(256, 999));
      3:       return $sformatf("00%0d", $urandom_range(0, 255));
      4:       return $sformatf("%0d", $urandom_range(65530, 99999999));
      default: return $sformatf("%0d", $urandom_range(0, 255));
    endcase
  endfunction

  function automatic string port_text();
    case ($urandom_range(0, 11))
      0:       return "1";
      1:       return "65535";
      2:       return "65536";
      3:       return "0";
      4:       return $sformatf("000%0d", $urandom_range(1, 999));
      5:       return $sformatf("%0d", $urandom_range(65536, 99999999));
      6:       return $sformatf("%0d", $urandom_range(0, 9));
      default: return $sformatf("%0d", $urandom_range(1, 65535));
    endcase
  endfunction

  task automatic add_garbage();
    repeat ($urandom_range(1, 4)) txt_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_address();
    logic [7:0] stop;
    for (int k = 0; k < 4; k++) begin
      add_text(octet_text());
      if (k < 3) add_text(".");
    end
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4, 5, 6: add_text({":", port_text()});
      7: begin
        add_text({":", port_text()});
        add_garbage();
      end
      8: begin
        stop = 8'($urandom_range(0, 255));
        if ((stop >= CH_ZERO && stop <= CH_NINE) || stop == CH_COLON) stop = CH_DOT;
        txt_q.push_back(stop);
        add_garbage();
      end
      default: begin
        add_text(":");
        add_garbage();
      end
    endcase
  endtask

  task automatic add_random_string();
    int pick;
    int pos;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      add_address();
    end else if (pick < 90) begin
      // A generated address string with one character replaced, dropped or inserted.
      add_address();
      pos = $urandom_range(0, txt_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       txt_q[pos] = 8'($urandom_range(0, 255));
        1:       txt_q.delete(pos);
        default: txt_q.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end else begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: txt_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          5, 6:          txt_q.push_back(CH_DOT);
          7:             txt_q.push_back(CH_COLON);
          default:       txt_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    flush_text();
  endtask

  task automatic build_directed();
    add_text("255.255.255.255:65535"); flush_text();
    add_text("0.0.0.0");               flush_text();
    add_text("001.02.3.0004:00080");   flush_text();
    add_text("256.1.1.1");             flush_text();
    add_text("1.2.3.4:65536");         flush_text();
    add_text("1.2.3.4:0");             flush_text();
    add_text("1.2.3.99999999");        flush_text();
    add_text("9.8.7.6:99999999x");     flush_text();
    // NUL after the fourth octet accepts; NUL at an octet or port start fails.
    add_text("1.2.3.4"); txt_q.push_back(8'h00); add_text("zz"); flush_text();
    txt_q.push_back(8'h00); add_text("1.2.3.4"); flush_text();
    add_text("10.0.0.1:"); txt_q.push_back(8'h00); flush_text();
    flush_text();
    add_text("1.2.3.");                flush_text();
    add_text("1.2.3.4:");              flush_text();
    add_text("1.2.3.4.5");             flush_text();
    add_text("1.2.3.4:80/x:9");        flush_text();
    add_text("1:2.3.4");               flush_text();
    add_text("1.2.3.4:1");             flush_text();
    txt_q.push_back(8'hFF); add_text("1.2.3.4"); flush_text();
  endtask

  // ---------------------------------------------------------------- driver

  int src_gap = 0;
  bit src_calm = 1'b0;

  always @(posedge clk) begin : source
    char_item_t nxt;
    ipap_res_t  res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_char(in_tdata, in_tlast, res)) verdict_q.push_back(res);
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (char_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else begin
          nxt = char_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.ch;
          in_tlast  <= nxt.eot;
          if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
          if (!src_calm && char_q.size() > QuietTail && $urandom_range(0, 6) == 0) begin
            src_gap = $urandom_range(1, 18);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int  sink_gap = 0;
  int  hold_left = 0;
  int  holds_done = 0;
  bit  sink_calm = 1'b0;

  always @(posedge clk) begin : sink
    ipap_res_t want;
    bit        quiet;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict pending: tuser=%0b tdata=%h",
                 out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tuser !== want.ok) begin
            $error("valid_res: expected %0b, got %0b", want.ok, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[31:0] !== want.ip) begin
            $error("ip_value: expected %h, got %h", want.ip, out_tdata[31:0]);
            mismatch_count++;
          end
          if (out_tdata[47:32] !== want.port) begin
            $error("port_value: expected %0d, got %0d", want.port, out_tdata[47:32]);
            mismatch_count++;
          end
        end
      end
      quiet = (results_seen + 8 >= results_total);
      if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
      // Two long hold-offs let the input side back up against a full result register.
      if (!quiet && hold_left == 0 && holds_done < 2 && results_seen >= 15 + 45 * holds_done) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && !sink_calm && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : run
    int start_size;
    parser_clear();
    build_directed();
    start_size = char_q.size();
    while (char_q.size() - start_size < RandomChars) add_random_string();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (char_q.size() != 0 || in_tvalid || verdict_q.size() != 0);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
